// File: src/aais_pkg.sv
package aais_pkg;

  localparam int unsigned MAX_SOURCE_WIDTH  = 256;
  localparam int unsigned MAX_SOURCE_HEIGHT = 256;
  localparam int unsigned MAX_SCREEN_WIDTH  = 320;
  localparam int unsigned MAX_SCREEN_HEIGHT = 240;

  localparam int unsigned DIV_W   = 64;
  localparam int unsigned WSUM_W  = 48;
  localparam int unsigned CSUM_W  = 56;
  localparam int unsigned FX_W    = 25;
  localparam int unsigned EDGE_W  = 26;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COV_W   = 17;

  localparam logic [1:0] FIT_LETTERBOX = 2'd1;
  localparam logic [1:0] FIT_CENTRE    = 2'd2;

  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FIT_MODE      = 3'd4;
  localparam logic [2:0] REG_BRIGHTNESS    = 3'd5;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [6:0] BRIGHT_MIN = 7'd10;
  localparam logic [6:0] BRIGHT_MAX = 7'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT,
    ST_FIT_DIV,
    ST_FIT_WAIT,
    ST_PLACE,
    ST_CHECK,
    ST_EDGE,
    ST_EDGE_WAIT,
    ST_SPAN,
    ST_RD,
    ST_WGT,
    ST_ACC,
    ST_SUM,
    ST_CH,
    ST_CH_WAIT
  } state_e;

endpackage

// File: src/aais_div.sv
module aais_div #(
  parameter int unsigned W = aais_pkg::DIV_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? W'(trial - {1'b0, den_q}) : W'(trial);
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: src/area_average_image_scaler_unit.sv
// Load transaction: an in-range pixel is written at the accepting edge; busy stays low.
// Render transaction: at most seven divisions (eight in letterbox or crop) on one shared
// bit-serial divider (64 steps), and a read-weigh-accumulate walk over the picture memory
// that visits every source pixel under the screen pixel.
// Result strobe the cycle after the last step, one render at a time; receiver cannot stall.
// Reset clears control state, loads default config; picture memory is undefined until written.
module area_average_image_scaler_unit #(
  parameter int unsigned MaxSrcW = aais_pkg::MAX_SOURCE_WIDTH,
  parameter int unsigned MaxSrcH = aais_pkg::MAX_SOURCE_HEIGHT,
  parameter int unsigned MaxScrW = aais_pkg::MAX_SCREEN_WIDTH,
  parameter int unsigned MaxScrH = aais_pkg::MAX_SCREEN_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [15:0] source_pixel_i,
  input  logic [8:0]  coord_x_i,
  input  logic [7:0]  coord_y_i,
  output logic        result_valid_o,
  output logic [15:0] screen_pixel_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);

  localparam int unsigned AX = (MaxSrcW > 1) ? $clog2(MaxSrcW) : 1;
  localparam int unsigned AY = (MaxSrcH > 1) ? $clog2(MaxSrcH) : 1;
  localparam int unsigned Depth = 2 ** (AX + AY);
  localparam int unsigned DW = aais_pkg::DIV_W;
  localparam int unsigned FW = aais_pkg::FX_W;
  localparam int unsigned EW = aais_pkg::EDGE_W;
  localparam int unsigned IW = aais_pkg::IDX_W;
  localparam int unsigned VW = aais_pkg::COV_W;
  localparam int unsigned SW = aais_pkg::WSUM_W;
  localparam int unsigned CS = aais_pkg::CSUM_W;

  // configuration
  logic [8:0] src_w_q, src_h_q, scr_w_q;
  logic [7:0] scr_h_q;
  logic [1:0] fit_q;
  logic [6:0] bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= 9'd256;
      src_h_q  <= 9'd256;
      scr_w_q  <= 9'd320;
      scr_h_q  <= 8'd240;
      fit_q    <= 2'd0;
      bright_q <= 7'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aais_pkg::REG_SOURCE_WIDTH:  src_w_q  <= cfg_wdata_i;
        aais_pkg::REG_SOURCE_HEIGHT: src_h_q  <= cfg_wdata_i;
        aais_pkg::REG_SCREEN_WIDTH:  scr_w_q  <= cfg_wdata_i;
        aais_pkg::REG_SCREEN_HEIGHT: scr_h_q  <= cfg_wdata_i[7:0];
        aais_pkg::REG_FIT_MODE:      fit_q    <= cfg_wdata_i[1:0];
        aais_pkg::REG_BRIGHTNESS:    bright_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  logic [8:0] sw, sh, dw, dh;
  logic [6:0] br;

  assign sw = (int'(src_w_q) > int'(MaxSrcW)) ? 9'(MaxSrcW) : src_w_q;
  assign sh = (int'(src_h_q) > int'(MaxSrcH)) ? 9'(MaxSrcH) : src_h_q;
  assign dw = (int'(scr_w_q) > int'(MaxScrW)) ? 9'(MaxScrW) : scr_w_q;
  assign dh = (int'({1'b0, scr_h_q}) > int'(MaxScrH)) ? 9'(MaxScrH) : {1'b0, scr_h_q};
  assign br = (bright_q < aais_pkg::BRIGHT_MIN) ? aais_pkg::BRIGHT_MIN :
              (bright_q > aais_pkg::BRIGHT_MAX) ? aais_pkg::BRIGHT_MAX : bright_q;

  // picture memory
  logic [15:0]       mem [Depth];
  logic              mem_we, mem_re;
  logic [AX+AY-1:0]  waddr, raddr;
  logic [15:0]       rdata_q;

  assign mem_we = start && !busy && (opcode_i == aais_pkg::OP_LOAD) &&
                  (int'(coord_x_i) < int'(MaxSrcW)) && (int'(coord_y_i) < int'(MaxSrcH));
  assign waddr  = {AY'(coord_y_i), AX'(coord_x_i)};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= source_pixel_i;
    if (mem_re) rdata_q <= mem[raddr];
  end

  // divider
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den, div_quo;

  aais_div #(.W(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // datapath state
  aais_pkg::state_e state_q, state_d;
  logic [8:0]    sx_q, sx_d;
  logic [7:0]    sy_q, sy_d;
  logic          le_q, le_d, ge_q, ge_d;
  logic [17:0]   pa_q, pa_d, pb_q, pb_d;
  logic [8:0]    pw_q, pw_d, ph_q, ph_d, pxo_q, pxo_d, pyo_q, pyo_d;
  logic [FW-1:0] ww_q, ww_d, wh_q, wh_d, wx_q, wx_d, wy_q, wy_d;
  logic [8:0]    px_q, px_d, py_q, py_d;
  logic [1:0]    e_q, e_d;
  logic [EW-1:0] x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [IW-1:0] ix_q, ix_d, iy_q, iy_d, ix0_q, ix0_d, ix1_q, ix1_d, iy1_q, iy1_d;
  logic [VW-1:0] wxv_q, wxv_d, wyv_q, wyv_d, wgt_q, wgt_d;
  logic [CS-1:0] rs_q, rs_d, gs_q, gs_d, bs_q, bs_d;
  logic [SW-1:0] ws_q, ws_d;
  logic [1:0]    ch_q, ch_d;
  logic [7:0]    r_q, r_d, g_q, g_d;
  logic [15:0]   pix_q, pix_d;
  logic          done_q, done_d;

  // combinational helpers
  logic [9:0]    edge_k;
  logic [FW-1:0] edge_base;
  logic [34:0]   edge_prod;
  logic [8:0]    edge_den;
  logic [EW-1:0] edge_val;
  logic [IW:0]   cx1, cy1;
  logic [EW:0]   xlo, xhi, ylo, yhi, xh, xl, yh, yl;
  logic [33:0]   wprod;
  logic [7:0]    cr, cg, cb;
  logic [CS-1:0] ch_sum;
  logic [DW-1:0] ch_mul, ch_num, ch_den;
  logic [7:0]    ch_q8;
  logic [19:0]   fq;

  assign edge_k    = e_q[0] ? ({1'b0, e_q[1] ? py_q : px_q} + 10'd1)
                            : {1'b0, e_q[1] ? py_q : px_q};
  assign edge_base = e_q[1] ? wh_q : ww_q;
  assign edge_prod = edge_k * edge_base;
  assign edge_den  = e_q[1] ? ph_q : pw_q;
  assign edge_val  = EW'(div_quo[EW-1:0]) + EW'(e_q[1] ? wy_q : wx_q);

  assign cx1 = (IW+1)'((x1_q + EW'(16'hFFFF)) >> 16);
  assign cy1 = (IW+1)'((y1_q + EW'(16'hFFFF)) >> 16);

  assign xlo = {1'b0, EW'(ix_q) << 16};
  assign xhi = xlo + (EW+1)'(32'h10000);
  assign ylo = {1'b0, EW'(iy_q) << 16};
  assign yhi = ylo + (EW+1)'(32'h10000);
  assign xh  = (xhi < {1'b0, x1_q}) ? xhi : {1'b0, x1_q};
  assign xl  = (xlo > {1'b0, x0_q}) ? xlo : {1'b0, x0_q};
  assign yh  = (yhi < {1'b0, y1_q}) ? yhi : {1'b0, y1_q};
  assign yl  = (ylo > {1'b0, y0_q}) ? ylo : {1'b0, y0_q};

  assign raddr = {AY'(iy_q), AX'(ix_q)};
  assign wprod = wxv_q * wyv_q;

  assign cr = {rdata_q[15:11], rdata_q[15:13]};
  assign cg = {rdata_q[10:5], rdata_q[10:9]};
  assign cb = {rdata_q[4:0], rdata_q[4:2]};

  always_comb begin
    unique case (ch_q)
      2'd0:    ch_sum = rs_q;
      2'd1:    ch_sum = gs_q;
      default: ch_sum = bs_q;
    endcase
  end

  assign ch_mul = ch_sum * {br, 1'b0};
  assign ch_num = ch_mul + ws_q * 64'd100;
  assign ch_den = ws_q * 64'd200;
  assign ch_q8  = (div_quo > DW'(255)) ? 8'd255 : div_quo[7:0];
  assign fq     = div_quo[19:0];

  always_comb begin
    state_d = state_q;
    sx_d = sx_q;   sy_d = sy_q;
    le_d = le_q;   ge_d = ge_q;
    pa_d = pa_q;   pb_d = pb_q;
    pw_d = pw_q;   ph_d = ph_q;   pxo_d = pxo_q; pyo_d = pyo_q;
    ww_d = ww_q;   wh_d = wh_q;   wx_d = wx_q;   wy_d = wy_q;
    px_d = px_q;   py_d = py_q;   e_d = e_q;
    x0_d = x0_q;   x1_d = x1_q;   y0_d = y0_q;   y1_d = y1_q;
    ix_d = ix_q;   iy_d = iy_q;   ix0_d = ix0_q; ix1_d = ix1_q; iy1_d = iy1_q;
    wxv_d = wxv_q; wyv_d = wyv_q; wgt_d = wgt_q;
    rs_d = rs_q;   gs_d = gs_q;   bs_d = bs_q;   ws_d = ws_q;
    ch_d = ch_q;   r_d = r_q;     g_d = g_q;
    pix_d = pix_q;
    done_d = 1'b0;
    mem_re = 1'b0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;

    unique case (state_q)
      aais_pkg::ST_IDLE: begin
        if (start && opcode_i == aais_pkg::OP_RENDER) begin
          sx_d = coord_x_i;
          sy_d = coord_y_i;
          pw_d = dw;
          ph_d = dh;
          ww_d = FW'(sw) << 16;
          wh_d = FW'(sh) << 16;
          pxo_d = '0;
          pyo_d = '0;
          wx_d = '0;
          wy_d = '0;
          if (sw == '0 || sh == '0 || dw == '0 || dh == '0) begin
            pix_d = '0;
            done_d = 1'b1;
          end else begin
            state_d = aais_pkg::ST_FIT;
          end
        end
      end
      aais_pkg::ST_FIT: begin
        pa_d = dw * sh;
        pb_d = dh * sw;
        state_d = aais_pkg::ST_FIT_DIV;
      end
      aais_pkg::ST_FIT_DIV: begin
        le_d = pa_q <= pb_q;
        ge_d = pa_q >= pb_q;
        if (fit_q == aais_pkg::FIT_LETTERBOX) begin
          div_start = 1'b1;
          if (pa_q <= pb_q) begin
            div_num = DW'({pa_q, 1'b0}) + DW'(sw);
            div_den = DW'({sw, 1'b0});
          end else begin
            div_num = DW'({pb_q, 1'b0}) + DW'(sh);
            div_den = DW'({sh, 1'b0});
          end
          state_d = aais_pkg::ST_FIT_WAIT;
        end else if (fit_q == aais_pkg::FIT_CENTRE) begin
          div_start = 1'b1;
          if (pa_q >= pb_q) begin
            div_num = DW'({pb_q, 16'h0000});
            div_den = DW'(dw);
          end else begin
            div_num = DW'({pa_q, 16'h0000});
            div_den = DW'(dh);
          end
          state_d = aais_pkg::ST_FIT_WAIT;
        end else begin
          state_d = aais_pkg::ST_PLACE;
        end
      end
      aais_pkg::ST_FIT_WAIT: begin
        if (div_done) begin
          if (fit_q == aais_pkg::FIT_LETTERBOX) begin
            if (le_q) begin
              ph_d = (fq == '0) ? 9'd1 : ((fq > 20'(dh)) ? dh : fq[8:0]);
            end else begin
              pw_d = (fq == '0) ? 9'd1 : ((fq > 20'(dw)) ? dw : fq[8:0]);
            end
          end else begin
            if (ge_q) wh_d = div_quo[FW-1:0];
            else      ww_d = div_quo[FW-1:0];
          end
          state_d = aais_pkg::ST_PLACE;
        end
      end
      aais_pkg::ST_PLACE: begin
        pxo_d = (dw - pw_q) >> 1;
        pyo_d = (dh - ph_q) >> 1;
        wx_d  = ((FW'(sw) << 16) - ww_q) >> 1;
        wy_d  = ((FW'(sh) << 16) - wh_q) >> 1;
        state_d = aais_pkg::ST_CHECK;
      end
      aais_pkg::ST_CHECK: begin
        if ({1'b0, sx_q} < {1'b0, pxo_q} || {1'b0, sx_q} >= {1'b0, pxo_q} + {1'b0, pw_q} ||
            {1'b0, sy_q} < {1'b0, pyo_q} ||
            {2'b0, sy_q} >= {1'b0, pyo_q} + {1'b0, ph_q}) begin
          pix_d = '0;
          done_d = 1'b1;
          state_d = aais_pkg::ST_IDLE;
        end else begin
          px_d = sx_q - pxo_q;
          py_d = {1'b0, sy_q} - pyo_q;
          e_d = '0;
          state_d = aais_pkg::ST_EDGE;
        end
      end
      aais_pkg::ST_EDGE: begin
        div_start = 1'b1;
        div_num = DW'(edge_prod);
        div_den = DW'(edge_den);
        state_d = aais_pkg::ST_EDGE_WAIT;
      end
      aais_pkg::ST_EDGE_WAIT: begin
        if (div_done) begin
          unique case (e_q)
            2'd0:    x0_d = edge_val;
            2'd1:    x1_d = edge_val;
            2'd2:    y0_d = edge_val;
            default: y1_d = edge_val;
          endcase
          e_d = e_q + 2'd1;
          state_d = (e_q == 2'd3) ? aais_pkg::ST_SPAN : aais_pkg::ST_EDGE;
        end
      end
      aais_pkg::ST_SPAN: begin
        ix0_d = IW'(x0_q >> 16);
        ix_d  = IW'(x0_q >> 16);
        iy_d  = IW'(y0_q >> 16);
        ix1_d = (cx1 > (IW+1)'(sw)) ? IW'(sw) : IW'(cx1);
        iy1_d = (cy1 > (IW+1)'(sh)) ? IW'(sh) : IW'(cy1);
        rs_d = '0;
        gs_d = '0;
        bs_d = '0;
        ws_d = '0;
        if (IW'(x0_q >> 16) >= ix1_d || IW'(y0_q >> 16) >= iy1_d) begin
          state_d = aais_pkg::ST_SUM;
        end else begin
          state_d = aais_pkg::ST_RD;
        end
      end
      aais_pkg::ST_RD: begin
        mem_re = 1'b1;
        wxv_d = (xh > xl) ? VW'(xh - xl) : '0;
        wyv_d = (yh > yl) ? VW'(yh - yl) : '0;
        state_d = aais_pkg::ST_WGT;
      end
      aais_pkg::ST_WGT: begin
        wgt_d = VW'(wprod >> 16);
        state_d = aais_pkg::ST_ACC;
      end
      aais_pkg::ST_ACC: begin
        rs_d = rs_q + wgt_q * cr;
        gs_d = gs_q + wgt_q * cg;
        bs_d = bs_q + wgt_q * cb;
        ws_d = ws_q + SW'(wgt_q);
        if (ix_q + 1'b1 < ix1_q) begin
          ix_d = ix_q + 1'b1;
          state_d = aais_pkg::ST_RD;
        end else begin
          ix_d = ix0_q;
          iy_d = iy_q + 1'b1;
          state_d = (iy_q + 1'b1 < iy1_q) ? aais_pkg::ST_RD : aais_pkg::ST_SUM;
        end
      end
      aais_pkg::ST_SUM: begin
        ch_d = '0;
        if (ws_q == '0) begin
          pix_d = '0;
          done_d = 1'b1;
          state_d = aais_pkg::ST_IDLE;
        end else begin
          state_d = aais_pkg::ST_CH;
        end
      end
      aais_pkg::ST_CH: begin
        div_start = 1'b1;
        div_num = ch_num;
        div_den = ch_den;
        state_d = aais_pkg::ST_CH_WAIT;
      end
      aais_pkg::ST_CH_WAIT: begin
        if (div_done) begin
          ch_d = ch_q + 2'd1;
          if (ch_q == 2'd0) begin
            r_d = ch_q8;
            state_d = aais_pkg::ST_CH;
          end else if (ch_q == 2'd1) begin
            g_d = ch_q8;
            state_d = aais_pkg::ST_CH;
          end else begin
            pix_d = {r_q[7:3], g_q[7:2], ch_q8[7:3]};
            done_d = 1'b1;
            state_d = aais_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = aais_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aais_pkg::ST_IDLE;
      done_q  <= 1'b0;
      e_q     <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      e_q     <= e_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= sx_d;   sy_q <= sy_d;
    le_q <= le_d;   ge_q <= ge_d;
    pa_q <= pa_d;   pb_q <= pb_d;
    pw_q <= pw_d;   ph_q <= ph_d;   pxo_q <= pxo_d; pyo_q <= pyo_d;
    ww_q <= ww_d;   wh_q <= wh_d;   wx_q <= wx_d;   wy_q <= wy_d;
    px_q <= px_d;   py_q <= py_d;
    x0_q <= x0_d;   x1_q <= x1_d;   y0_q <= y0_d;   y1_q <= y1_d;
    ix_q <= ix_d;   iy_q <= iy_d;   ix0_q <= ix0_d; ix1_q <= ix1_d; iy1_q <= iy1_d;
    wxv_q <= wxv_d; wyv_q <= wyv_d; wgt_q <= wgt_d;
    rs_q <= rs_d;   gs_q <= gs_d;   bs_q <= bs_d;   ws_q <= ws_d;
    r_q <= r_d;     g_q <= g_d;
    pix_q <= pix_d;
  end

  assign busy           = state_q != aais_pkg::ST_IDLE;
  assign result_valid_o = done_q;
  assign screen_pixel_o = pix_q;

endmodule

// File: sim/tb.sv
module tb;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned DRAIN = 40;
  localparam int FILL = 32;

  typedef enum int {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e kind;
    int        a, b, c, d, e, f;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = aais_pkg::OP_LOAD;
  logic [15:0] source_pixel_i = '0;
  logic [8:0]  coord_x_i = '0;
  logic [7:0]  coord_y_i = '0;
  logic        result_valid_o;
  logic [15:0] screen_pixel_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = aais_pkg::REG_SOURCE_WIDTH;
  logic [8:0]  cfg_wdata_i = '0;

  logic [15:0] picture [0:65535];
  logic [8:0]  src_w, src_h, scr_w;
  logic [7:0]  scr_h;
  logic [1:0]  fit;
  logic [6:0]  bright;

  logic [15:0] exp_pixels [$];
  int unsigned err_cnt = 0;
  longint unsigned cycles = 0;
  row_t dir [0:30];
  int   n_dir;

  area_average_image_scaler_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .source_pixel_i, .coord_x_i, .coord_y_i,
    .result_valid_o, .screen_pixel_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (exp_pixels.size() == 0) begin
        $error("screen_pixel: unexpected transaction, actual %h", screen_pixel_o);
        err_cnt++;
      end else begin
        logic [15:0] want;
        want = exp_pixels.pop_front();
        if (screen_pixel_o !== want) begin
          $error("screen_pixel: expected %h actual %h", want, screen_pixel_o);
          err_cnt++;
        end
      end
    end
  end

  function automatic longint unsigned umin(longint unsigned p, longint unsigned q);
    return p < q ? p : q;
  endfunction

  function automatic longint unsigned widen(longint unsigned c5);
    return (c5 << 3) | (c5 >> 2);
  endfunction

  function automatic longint unsigned chan(longint unsigned s, longint unsigned ws,
                                           longint unsigned br);
    longint unsigned v;
    v = (2 * s * br + 100 * ws) / (200 * ws);
    return v > 255 ? 255 : v;
  endfunction

  function automatic logic [15:0] area_average(longint unsigned sx, longint unsigned sy);
    longint unsigned sw, sh, dw, dh, br, pxo, pyo, pw, ph, wx, wy, ww, wh;
    longint unsigned px, py, x0, x1, y0, y1, ix0, ix1, iy0, iy1, rs, gs, bs, ws;
    longint unsigned r, g, b, wgt, c, g6;
    longint wxv, wyv;
    sw = umin(src_w, aais_pkg::MAX_SOURCE_WIDTH);
    sh = umin(src_h, aais_pkg::MAX_SOURCE_HEIGHT);
    dw = umin(scr_w, aais_pkg::MAX_SCREEN_WIDTH);
    dh = umin(scr_h, aais_pkg::MAX_SCREEN_HEIGHT);
    br = bright < aais_pkg::BRIGHT_MIN ? aais_pkg::BRIGHT_MIN :
         (bright > aais_pkg::BRIGHT_MAX ? aais_pkg::BRIGHT_MAX : bright);
    pxo = 0; pyo = 0; pw = dw; ph = dh; wx = 0; wy = 0;
    rs = 0; gs = 0; bs = 0; ws = 0;
    if (sw == 0 || sh == 0 || dw == 0 || dh == 0) return 16'h0;
    ww = sw << 16;
    wh = sh << 16;
    if (fit == aais_pkg::FIT_LETTERBOX) begin
      if (dw * sh <= dh * sw) begin
        pw = dw;
        ph = (2 * sh * dw + sw) / (2 * sw);
      end else begin
        ph = dh;
        pw = (2 * sw * dh + sh) / (2 * sh);
      end
      if (pw < 1) pw = 1;
      if (ph < 1) ph = 1;
      if (pw > dw) pw = dw;
      if (ph > dh) ph = dh;
      pxo = (dw - pw) / 2;
      pyo = (dh - ph) / 2;
    end else if (fit == aais_pkg::FIT_CENTRE) begin
      if (dw * sh >= dh * sw) wh = ((dh * sw) << 16) / dw;
      else ww = ((dw * sh) << 16) / dh;
      wx = ((sw << 16) - ww) / 2;
      wy = ((sh << 16) - wh) / 2;
    end
    if (sx < pxo || sx >= pxo + pw || sy < pyo || sy >= pyo + ph) return 16'h0;
    px = sx - pxo;
    py = sy - pyo;
    x0 = wx + (px * ww) / pw;
    x1 = wx + ((px + 1) * ww) / pw;
    y0 = wy + (py * wh) / ph;
    y1 = wy + ((py + 1) * wh) / ph;
    ix0 = x0 >> 16;
    ix1 = umin((x1 + 64'hFFFF) >> 16, sw);
    iy0 = y0 >> 16;
    iy1 = umin((y1 + 64'hFFFF) >> 16, sh);
    for (longint unsigned iy = iy0; iy < iy1; iy++) begin
      wyv = longint'(umin((iy << 16) + 65536, y1)) - longint'((iy << 16) > y0 ? (iy << 16) : y0);
      if (wyv <= 0) continue;
      for (longint unsigned ix = ix0; ix < ix1; ix++) begin
        wxv = longint'(umin((ix << 16) + 65536, x1))
            - longint'((ix << 16) > x0 ? (ix << 16) : x0);
        if (wxv <= 0) continue;
        wgt = (longint'(wxv) * longint'(wyv)) >> 16;
        c = picture[iy * 256 + ix];
        g6 = (c >> 5) & 63;
        rs += wgt * widen((c >> 11) & 31);
        gs += wgt * ((g6 << 2) | (g6 >> 4));
        bs += wgt * widen(c & 31);
        ws += wgt;
      end
    end
    if (ws == 0) return 16'h0;
    r = chan(rs, ws, br);
    g = chan(gs, ws, br);
    b = chan(bs, ws, br);
    return 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
  endfunction

  // called just after a falling edge; returns once the item is taken, just after a falling edge
  task automatic send_item(logic op, logic [15:0] pix, logic [8:0] x, logic [7:0] y,
                           int gap, bit typed = 0, logic [15:0] typed_val = '0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    source_pixel_i <= pix;
    coord_x_i <= x;
    coord_y_i <= y;
    do @(posedge clk_i); while (busy);
    if (op == aais_pkg::OP_RENDER) exp_pixels.push_back(typed ? typed_val : area_average(x, y));
    else if (x < aais_pkg::MAX_SOURCE_WIDTH) picture[{y, x[7:0]}] = pix;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (exp_pixels.size() != 0 || busy);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic set_config(int sw, int sh, int dw, int dh, int md, int br);
    int vals [6];
    vals = '{sw, sh, dw, dh, md, br};
    wait_idle();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_wdata_i <= 9'(vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    src_w = 9'(sw); src_h = 9'(sh); scr_w = 9'(dw);
    scr_h = 8'(dh); fit = 2'(md); bright = 7'(br);
  endtask

  task automatic random_phase(int n, bit no_gaps);
    int sw, sh, dw, dh;
    logic [8:0] x;
    logic [7:0] y;
    sw = $urandom_range(1, FILL);
    sh = $urandom_range(1, FILL);
    dw = $urandom_range((sw + 3) / 4, 320);
    dh = $urandom_range((sh + 3) / 4 > 240 ? 240 : (sh + 3) / 4, 240);
    if ($urandom_range(0, 19) == 0) sw = 0;
    if ($urandom_range(0, 19) == 0) dh = 0;
    set_config(sw, sh, dw, dh, $urandom_range(0, 3), $urandom_range(0, 127));
    for (int i = 0; i < n; i++) begin
      x = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, dw > 0 ? dw - 1 : 0));
      y = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, dh > 0 ? dh - 1 : 0));
      if ($urandom_range(0, 9) < 3)
        send_item(aais_pkg::OP_LOAD, 16'($urandom), 9'($urandom), 8'($urandom),
                  no_gaps ? 0 : $urandom_range(0, 9));
      else
        send_item(aais_pkg::OP_RENDER, 16'($urandom), x, y,
                  no_gaps ? 0 : $urandom_range(0, 9));
    end
  endtask

  initial begin
    n_dir = 0;
    dir[n_dir++] = '{ROW_CFG, 256, 256, 320, 240, 0, 100};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_LOAD, 16'hFFFF, 0, 0, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_LOAD, 16'h0000, 1, 0, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_LOAD, 16'h1234, 300, 5, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_LOAD, 16'hABCD, 511, 255, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 0, 0, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 16'hFFFF, 20, 20, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 320, 0, 1, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 511, 255, 1, 0};
    dir[n_dir++] = '{ROW_CFG, 511, 511, 511, 255, 3, 127};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 0, 0, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 30, 25, 0, 0};
    dir[n_dir++] = '{ROW_CFG, 0, 256, 320, 240, 0, 100};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 10, 10, 1, 0};
    dir[n_dir++] = '{ROW_CFG, 256, 64, 320, 240, 1, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 0, 0, 1, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 20, 85, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 39, 110, 0, 0};
    dir[n_dir++] = '{ROW_CFG, 32, 32, 320, 240, 2, 55};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 0, 0, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 319, 239, 0, 0};
    dir[n_dir++] = '{ROW_CFG, 1, 1, 1, 1, 1, 9};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 0, 0, 0, 0};
    dir[n_dir++] = '{ROW_ITEM, aais_pkg::OP_RENDER, 0, 1, 0, 1, 0};

    src_w = 9'd256; src_h = 9'd256; scr_w = 9'd320; scr_h = 8'd240;
    fit = 2'd0; bright = 7'd100;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill the corner of the picture store that the random-phase renders read from
    for (int i = 0; i < FILL * FILL; i++)
      send_item(aais_pkg::OP_LOAD, 16'($urandom), 9'(i % FILL), 8'(i / FILL), 0);

    for (int i = 0; i < n_dir; i++) begin
      if (dir[i].kind == ROW_CFG)
        set_config(dir[i].a, dir[i].b, dir[i].c, dir[i].d, dir[i].e, dir[i].f);
      else
        send_item(1'(dir[i].a), 16'(dir[i].b), 9'(dir[i].c), 8'(dir[i].d),
                  $urandom_range(0, 9), dir[i].e != 0, 16'(dir[i].f));
    end

    for (int p = 0; p < 12; p++) random_phase(55, p == 3);

    wait_idle();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
